>>> rtl/occ_pkg.sv
// Shared constants, types and helpers for the octree cell index pipeline.
package occ_pkg;

	// Tree depth: 2^LEVELS grid cells per axis, LEVELS tree levels (0 is the root).
	localparam int LEVELS = 4;

	localparam int POS_W   = 32;
	localparam int GRID_W  = LEVELS;
	localparam int CODE_W  = 3 * LEVELS;
	localparam int TOP_W   = $clog2(LEVELS + 1);
	localparam int NODE_W  = 10;
	localparam int LEVEL_W = 2;
	localparam int CELL_W  = 9;
	localparam int SUM_W   = (CODE_W > NODE_W) ? CODE_W : NODE_W;

	localparam logic [GRID_W-1:0] GRID_LAST = '1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Y   = 3'd1,
		REG_ORIGIN_Z   = 3'd2,
		REG_CELLS_PU_X = 3'd3,
		REG_CELLS_PU_Y = 3'd4,
		REG_CELLS_PU_Z = 3'd5
	} cfg_reg_t;

	// Load enables of the two stages inside one scaling unit.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
	} scale_en_t;

	// First node index of a level: (8^lvl - 1) / 7, built as 1 + 8 + 64 + ...
	function automatic logic [SUM_W-1:0] node_base(input logic [SUM_W-1:0] lvl);
		logic [SUM_W-1:0] start;
		logic [SUM_W-1:0] span;
		start = '0;
		span  = SUM_W'(1);
		for (int i = 0; i < LEVELS; i++) begin
			if (SUM_W'(i) < lvl) begin
				start = start + span;
				span  = span << 3;
			end
		end
		return start;
	endfunction

endpackage

>>> rtl/occ_axis_scale.sv
// One corner component: offset from the origin, then scaling to grid units.
module occ_axis_scale (
	input  logic                           clk,
	input  occ_pkg::scale_en_t             en,
	input  logic signed [occ_pkg::POS_W-1:0] pos,
	input  logic signed [occ_pkg::POS_W-1:0] origin,
	input  logic        [occ_pkg::POS_W-1:0] scale,
	output logic        [occ_pkg::POS_W-1:0] grid_s2
);

	logic [occ_pkg::POS_W:0]       diff;
	logic [occ_pkg::POS_W-1:0]     offset_s1;
	logic [2*occ_pkg::POS_W-1:0]   prod;

	// The offset is exact in 33 bits; zero or negative means grid coordinate 0.
	assign diff = {pos[occ_pkg::POS_W-1], pos} - {origin[occ_pkg::POS_W-1], origin};

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			if (!diff[occ_pkg::POS_W] && (diff != '0)) begin
				offset_s1 <= diff[occ_pkg::POS_W-1:0];
			end else begin
				offset_s1 <= '0;
			end
		end
	end

	// Unsigned 32 x 32 product in Q32.32; only the integer part is kept.
	assign prod = offset_s1 * scale;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			grid_s2 <= prod[2*occ_pkg::POS_W-1:occ_pkg::POS_W];
		end
	end

endmodule

>>> rtl/occ_morton.sv
// Grid clamping and bit interleaving of both corners into Morton codes.
module occ_morton (
	input  logic                                clk,
	input  logic                                en,
	input  logic [2:0][occ_pkg::POS_W-1:0]      grid_lo,
	input  logic [2:0][occ_pkg::POS_W-1:0]      grid_hi,
	output logic [occ_pkg::CODE_W-1:0]          code_lo_s3,
	output logic [occ_pkg::CODE_W-1:0]          code_hi_s3
);

	logic [2:0][occ_pkg::GRID_W-1:0] cl_lo;
	logic [2:0][occ_pkg::GRID_W-1:0] cl_hi;
	logic [occ_pkg::CODE_W-1:0]      code_lo;
	logic [occ_pkg::CODE_W-1:0]      code_hi;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (grid_lo[a] >= occ_pkg::POS_W'(occ_pkg::GRID_LAST)) begin
				cl_lo[a] = occ_pkg::GRID_LAST;
			end else begin
				cl_lo[a] = grid_lo[a][occ_pkg::GRID_W-1:0];
			end
			if (grid_hi[a] >= occ_pkg::POS_W'(occ_pkg::GRID_LAST)) begin
				cl_hi[a] = occ_pkg::GRID_LAST;
			end else begin
				cl_hi[a] = grid_hi[a][occ_pkg::GRID_W-1:0];
			end
		end
	end

	// x lands in bit 0, y in bit 1 and z in bit 2 of each 3-bit group.
	always_comb begin
		for (int b = 0; b < occ_pkg::LEVELS; b++) begin
			for (int a = 0; a < 3; a++) begin
				code_lo[3*b + a] = cl_lo[a][b];
				code_hi[3*b + a] = cl_hi[a][b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_lo_s3 <= code_lo;
			code_hi_s3 <= code_hi;
		end
	end

endmodule

>>> rtl/occ_node.sv
// Enclosing tree level, cell number and linear node index from two Morton codes.
module occ_node (
	input  logic                          clk,
	input  logic                          en,
	input  logic [occ_pkg::CODE_W-1:0]    code_lo,
	input  logic [occ_pkg::CODE_W-1:0]    code_hi,
	output logic [occ_pkg::NODE_W-1:0]    node_index_s4,
	output logic [occ_pkg::LEVEL_W-1:0]   tree_level_s4,
	output logic [occ_pkg::CELL_W-1:0]    cell_in_level_s4
);

	logic [occ_pkg::CODE_W-1:0] diff;
	logic [occ_pkg::TOP_W-1:0]  top;
	logic [occ_pkg::SUM_W-1:0]  level;
	logic [occ_pkg::SUM_W-1:0]  cell_no;
	logic [occ_pkg::SUM_W-1:0]  sum;

	assign diff = code_lo ^ code_hi;

	// Highest differing group sets the node size; equal codes give the deepest level.
	always_comb begin
		top = occ_pkg::TOP_W'(1);
		for (int i = 0; i < occ_pkg::LEVELS; i++) begin
			if (diff[3*i +: 3] != 3'b000) begin
				top = occ_pkg::TOP_W'(i + 1);
			end
		end
	end

	assign level = occ_pkg::SUM_W'(occ_pkg::LEVELS) - occ_pkg::SUM_W'(top);

	always_comb begin
		cell_no = '0;
		for (int t = 1; t <= occ_pkg::LEVELS; t++) begin
			if (top == occ_pkg::TOP_W'(t)) begin
				cell_no = occ_pkg::SUM_W'(code_hi >> (3 * t));
			end
		end
	end

	assign sum = occ_pkg::node_base(level) + cell_no;

	always_ff @(posedge clk) begin
		if (en) begin
			node_index_s4    <= sum[occ_pkg::NODE_W-1:0];
			tree_level_s4    <= level[occ_pkg::LEVEL_W-1:0];
			cell_in_level_s4 <= cell_no[occ_pkg::CELL_W-1:0];
		end
	end

endmodule

>>> rtl/octree_cell_index.sv
// Top level of the octree cell index pipeline: configuration, stage control, datapath.
//
// Use: each transfer on the input channel carries one axis-aligned box (min and max
// corners, signed Q16.16). For every box exactly one result transfer follows on the
// output channel with the linear octree node index, the tree level and the Morton
// cell number of the smallest node that holds the whole box. Results leave in order.
// The stages are offset (s1), 32 x 32 scaling multiply (s2), clamp and interleave
// (s3), level search and index add (s4, which is also the output register).
// Throughput is one box per cycle while out_ready is high; the six scaling multipliers
// of stage two set the cycle time. A stalled receiver holds the result in stage four;
// earlier stages keep moving and squeeze out empty slots, so new boxes are still
// taken until all four stages are full. in_ready follows out_ready combinationally
// through that chain. Reset clears all stage valid bits and restores origin 0 and
// scale 1.0 on each axis. Configuration writes are registered; the user must make
// them only while the pipeline is empty, as the block itself does not enforce this.
module octree_cell_index (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [occ_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [occ_pkg::POS_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [occ_pkg::POS_W-1:0]      box_min_x,
	input  logic signed [occ_pkg::POS_W-1:0]      box_min_y,
	input  logic signed [occ_pkg::POS_W-1:0]      box_min_z,
	input  logic signed [occ_pkg::POS_W-1:0]      box_max_x,
	input  logic signed [occ_pkg::POS_W-1:0]      box_max_y,
	input  logic signed [occ_pkg::POS_W-1:0]      box_max_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [occ_pkg::NODE_W-1:0]            node_index,
	output logic [occ_pkg::LEVEL_W-1:0]           tree_level,
	output logic [occ_pkg::CELL_W-1:0]            cell_in_level
);

	localparam logic [occ_pkg::POS_W-1:0] SCALE_ONE = occ_pkg::POS_W'(65536);

	// Configuration registers.
	logic [occ_pkg::POS_W-1:0] origin_x_q, origin_y_q, origin_z_q;
	logic [occ_pkg::POS_W-1:0] cpu_x_q, cpu_y_q, cpu_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			cpu_x_q    <= SCALE_ONE;
			cpu_y_q    <= SCALE_ONE;
			cpu_z_q    <= SCALE_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				occ_pkg::REG_ORIGIN_X:   origin_x_q <= cfg_data;
				occ_pkg::REG_ORIGIN_Y:   origin_y_q <= cfg_data;
				occ_pkg::REG_ORIGIN_Z:   origin_z_q <= cfg_data;
				occ_pkg::REG_CELLS_PU_X: cpu_x_q    <= cfg_data;
				occ_pkg::REG_CELLS_PU_Y: cpu_y_q    <= cfg_data;
				occ_pkg::REG_CELLS_PU_Z: cpu_z_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage control: a stage loads when it is empty or its successor is loading,
	// so a stall at the output only blocks the input once every stage is full.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready_s1, ready_s2, ready_s3, ready_s4;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	occ_pkg::scale_en_t scale_en;
	assign scale_en.en_s1 = ready_s1;
	assign scale_en.en_s2 = ready_s2;

	// Per-axis operands. Raising the min corner to the origin needs no logic of its
	// own: any corner at or below the origin already maps to grid coordinate 0.
	logic [2:0][occ_pkg::POS_W-1:0] min_pos, max_pos, origin_v, scale_v;
	logic [2:0][occ_pkg::POS_W-1:0] grid_lo, grid_hi;

	assign min_pos  = {box_min_z, box_min_y, box_min_x};
	assign max_pos  = {box_max_z, box_max_y, box_max_x};
	assign origin_v = {origin_z_q, origin_y_q, origin_x_q};
	assign scale_v  = {cpu_z_q, cpu_y_q, cpu_x_q};

	for (genvar a = 0; a < 3; a++) begin : g_axis
		occ_axis_scale u_lo (
			.clk     (clk),
			.en      (scale_en),
			.pos     (min_pos[a]),
			.origin  (origin_v[a]),
			.scale   (scale_v[a]),
			.grid_s2 (grid_lo[a])
		);
		occ_axis_scale u_hi (
			.clk     (clk),
			.en      (scale_en),
			.pos     (max_pos[a]),
			.origin  (origin_v[a]),
			.scale   (scale_v[a]),
			.grid_s2 (grid_hi[a])
		);
	end

	logic [occ_pkg::CODE_W-1:0] code_lo_s3, code_hi_s3;

	occ_morton u_morton (
		.clk        (clk),
		.en         (ready_s3),
		.grid_lo    (grid_lo),
		.grid_hi    (grid_hi),
		.code_lo_s3 (code_lo_s3),
		.code_hi_s3 (code_hi_s3)
	);

	occ_node u_node (
		.clk              (clk),
		.en               (ready_s4),
		.code_lo          (code_lo_s3),
		.code_hi          (code_hi_s3),
		.node_index_s4    (node_index),
		.tree_level_s4    (tree_level),
		.cell_in_level_s4 (cell_in_level)
	);

	assign out_valid = valid_s4;

`ifndef SYNTHESIS
	// Any empty stage must let a new box in.
	a_bubble_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 || !valid_s2 || !valid_s3 || !valid_s4) |-> in_ready)
		else $error("pipeline has an empty stage but refuses input");

	// A full pipeline with a stalled receiver must refuse input.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !out_ready) |-> !in_ready)
		else $error("full pipeline accepted input during a stall");

	// An item in stage three moves into an empty output stage on the next edge.
	a_s3_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !valid_s4) |=> valid_s4)
		else $error("item in stage three did not reach the output register");

	// A transfer out with nothing behind it and no new input leaves stage four empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && out_ready && !valid_s3) |=> !valid_s4)
		else $error("result repeated after its transfer");
`endif

endmodule
